// ===== design/nppm_pkg.sv =====
// Shared types and constants for the normal plane point merge block.
package nppm_pkg;

  localparam int POS_W = 24;
  localparam int NRM_W = 16;
  localparam int THR_W = 15;
  localparam int TOL_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DOT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOLERANCE = 2'd1;

  localparam logic [THR_W-1:0] DOT_THRESHOLD_RESET = 15'd13107;
  localparam logic [TOL_W-1:0] PLANE_TOLERANCE_RESET = 16'd328;

  typedef struct packed {
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic signed [NRM_W-1:0] first_nx;
    logic signed [NRM_W-1:0] first_ny;
    logic signed [NRM_W-1:0] first_nz;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
    logic signed [NRM_W-1:0] second_nx;
    logic signed [NRM_W-1:0] second_ny;
    logic signed [NRM_W-1:0] second_nz;
  } in_t;

  typedef struct packed {
    logic                    merge_ok;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic signed [NRM_W-1:0] out_nx;
    logic signed [NRM_W-1:0] out_ny;
    logic signed [NRM_W-1:0] out_nz;
  } out_t;

endpackage

// ===== design/normal_plane_point_merge_top.sv =====
// Top level of the normal plane point merge block.
// One point pair per cycle goes in while the output is not stalled, and one result per
// pair comes out, in order, after an input register, a register holding the nine 16x16
// and 25x17 products (the projection is formed for both the normal sum and the normal
// difference), and the result register where the sums are compared against the
// thresholds. The pipeline fills bubbles, so stall reaches the input only when all three
// stages hold a transaction and the output is stalled. Configuration registers are read
// directly and must be written only while the pipeline is empty.
module normal_plane_point_merge_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  nppm_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output nppm_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [nppm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nppm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import nppm_pkg::*;

  localparam int DP_W = POS_W + 1;
  localparam int M_W = NRM_W + 1;
  localparam int DOTP_W = 2 * NRM_W;
  localparam int DOTS_W = DOTP_W + 2;
  localparam int PROJP_W = DP_W + M_W;
  localparam int PROJS_W = PROJP_W + 2;

  logic [THR_W-1:0] dot_threshold;
  logic [TOL_W-1:0] plane_tolerance;

  logic s1_valid;
  in_t  s1;
  logic s2_valid;
  logic signed [DOTP_W-1:0]  s2_dot  [3];
  logic signed [PROJP_W-1:0] s2_psum [3];
  logic signed [PROJP_W-1:0] s2_pdif [3];
  out_t s2_merged;
  out_t s2_first;

  logic en_out, en2, en1;

  assign en_out = !out_valid || !out_stall;
  assign en2 = !s2_valid || en_out;
  assign en1 = !s1_valid || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_threshold <= DOT_THRESHOLD_RESET;
      plane_tolerance <= PLANE_TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOT_THRESHOLD: dot_threshold <= cfg_data[THR_W-1:0];
        REG_PLANE_TOLERANCE: plane_tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1 -> 2: products and halved sums
  logic signed [POS_W-1:0] p1 [3];
  logic signed [POS_W-1:0] p2 [3];
  logic signed [NRM_W-1:0] n1 [3];
  logic signed [NRM_W-1:0] n2 [3];
  logic signed [DOTP_W-1:0]  dot_next  [3];
  logic signed [PROJP_W-1:0] psum_next [3];
  logic signed [PROJP_W-1:0] pdif_next [3];
  logic signed [DP_W-1:0]    pos_add   [3];
  logic signed [M_W-1:0]     nrm_add   [3];

  always_comb begin
    logic signed [DP_W-1:0] dp;
    logic signed [M_W-1:0]  ms;
    logic signed [M_W-1:0]  md;
    p1[0] = s1.first_x;   p1[1] = s1.first_y;   p1[2] = s1.first_z;
    p2[0] = s1.second_x;  p2[1] = s1.second_y;  p2[2] = s1.second_z;
    n1[0] = s1.first_nx;  n1[1] = s1.first_ny;  n1[2] = s1.first_nz;
    n2[0] = s1.second_nx; n2[1] = s1.second_ny; n2[2] = s1.second_nz;
    for (int i = 0; i < 3; i++) begin
      dp = DP_W'(p1[i]) - DP_W'(p2[i]);
      ms = M_W'(n1[i]) + M_W'(n2[i]);
      md = M_W'(n1[i]) - M_W'(n2[i]);
      dot_next[i] = DOTP_W'(n1[i]) * DOTP_W'(n2[i]);
      psum_next[i] = PROJP_W'(dp) * PROJP_W'(ms);
      pdif_next[i] = PROJP_W'(dp) * PROJP_W'(md);
      pos_add[i] = DP_W'(p1[i]) + DP_W'(p2[i]);
      nrm_add[i] = ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) s1 <= in_data;
    if (en2 && s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        s2_dot[i] <= dot_next[i];
        s2_psum[i] <= psum_next[i];
        s2_pdif[i] <= pdif_next[i];
      end
      s2_merged.merge_ok <= 1'b1;
      s2_merged.out_x <= pos_add[0][DP_W-1:1];
      s2_merged.out_y <= pos_add[1][DP_W-1:1];
      s2_merged.out_z <= pos_add[2][DP_W-1:1];
      s2_merged.out_nx <= nrm_add[0][M_W-1:1];
      s2_merged.out_ny <= nrm_add[1][M_W-1:1];
      s2_merged.out_nz <= nrm_add[2][M_W-1:1];
      s2_first.merge_ok <= 1'b0;
      s2_first.out_x <= s1.first_x;
      s2_first.out_y <= s1.first_y;
      s2_first.out_z <= s1.first_z;
      s2_first.out_nx <= s1.first_nx;
      s2_first.out_ny <= s1.first_ny;
      s2_first.out_nz <= s1.first_nz;
    end
  end

  // stage 2 -> 3: sums and compares
  logic signed [DOTS_W-1:0]  dot_sum;
  logic signed [DOTS_W-1:0]  thr;
  logic signed [PROJS_W-1:0] proj_sum;
  logic signed [PROJS_W-1:0] proj_dif;
  logic signed [PROJS_W-1:0] proj;
  logic signed [PROJS_W-1:0] tol;
  logic same, opposed, ok;

  always_comb begin
    dot_sum = DOTS_W'(s2_dot[0]) + DOTS_W'(s2_dot[1]) + DOTS_W'(s2_dot[2]);
    proj_sum = PROJS_W'(s2_psum[0]) + PROJS_W'(s2_psum[1]) + PROJS_W'(s2_psum[2]);
    proj_dif = PROJS_W'(s2_pdif[0]) + PROJS_W'(s2_pdif[1]) + PROJS_W'(s2_pdif[2]);
    thr = $signed({{(DOTS_W-THR_W-14){1'b0}}, dot_threshold, 14'b0});
    tol = $signed({{(PROJS_W-TOL_W-15){1'b0}}, plane_tolerance, 15'b0});
    same = dot_sum > thr;
    opposed = dot_sum < -thr;
    proj = same ? proj_sum : proj_dif;
    ok = (same || opposed) && (proj >= -tol) && (proj <= tol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_valid) out_data <= ok ? s2_merged : s2_first;
  end

endmodule

// ===== design/nppm_checker.sv =====
// Port-level assertions for the normal plane point merge block, with bind.
module nppm_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input nppm_pkg::out_t out_data
);
  import nppm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted transaction did not reach the output");

endmodule

bind normal_plane_point_merge_top nppm_checker u_nppm_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);
